/* sv/scrm_pkg.sv */
// Shared request codes, status codes and control types of the slot ring manager.
package scrm_pkg;

    localparam logic [2:0] REQ_PRODUCE = 3'd0;
    localparam logic [2:0] REQ_PROCESS = 3'd1;
    localparam logic [2:0] REQ_CONSUME = 3'd2;
    localparam logic [2:0] REQ_RELEASE = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_BAD_STATE = 2'd1;
    localparam logic [1:0] STAT_TOO_LONG  = 2'd2;

    localparam int unsigned LEN_W = 16;
    localparam int unsigned IDX_W = 3;

    // Decision of the control stage for one request.
    typedef struct packed {
        logic [1:0] status;
        logic       len_sel;   // Show the stored length on the result.
        logic       chg_sel;   // Show the stored new-picture flag on the result.
        logic       len_we;    // Write the offered length into the fill slot.
        logic       chg_we;    // Write the decoder outcome into the work slot.
    } scrm_ctl_t;

endpackage

/* sv/scrm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module scrm_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/scrm_ctrl.sv */
// Pointer and occupancy control of the slot ring: decides and applies one request per cycle.
module scrm_ctrl #(
    parameter int unsigned NUM_SLOTS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_vld,
    input  logic [2:0]                   req_type,
    input  logic [scrm_pkg::LEN_W-1:0]   frame_len,
    input  logic [scrm_pkg::LEN_W-1:0]   max_frame_len,
    output scrm_pkg::scrm_ctl_t          ctl,
    output logic [$clog2(NUM_SLOTS)-1:0] slot_ptr,
    output logic [$clog2(NUM_SLOTS)-1:0] fill_ptr,
    output logic [$clog2(NUM_SLOTS)-1:0] work_ptr,
    output logic [$clog2(NUM_SLOTS)-1:0] drain_ptr
);

    localparam int unsigned PW = $clog2(NUM_SLOTS);
    localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(NUM_SLOTS - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(NUM_SLOTS);

    // The ring is strictly ordered, so slot states follow from two counts:
    // occupied slots start at the drain pointer, processed ones are the
    // first of them, and filled ones start at the work pointer.
    logic [PW-1:0] fill_ptr_reg, fill_ptr_next;
    logic [PW-1:0] work_ptr_reg, work_ptr_next;
    logic [PW-1:0] drain_ptr_reg, drain_ptr_next;
    logic [CW-1:0] occ_cnt_reg, occ_cnt_next;
    logic [CW-1:0] proc_cnt_reg, proc_cnt_next;

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == LAST_SLOT)
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        ctl            = '0;
        ctl.status     = scrm_pkg::STAT_BAD_STATE;
        slot_ptr       = '0;
        fill_ptr_next  = fill_ptr_reg;
        work_ptr_next  = work_ptr_reg;
        drain_ptr_next = drain_ptr_reg;
        occ_cnt_next   = occ_cnt_reg;
        proc_cnt_next  = proc_cnt_reg;
        case (req_type)
            scrm_pkg::REQ_PRODUCE:
            begin
                slot_ptr = fill_ptr_reg;
                if (frame_len > max_frame_len)
                begin
                    ctl.status = scrm_pkg::STAT_TOO_LONG;
                end
                else if (occ_cnt_reg != FULL_CNT)
                begin
                    ctl.status    = scrm_pkg::STAT_DONE;
                    ctl.len_we    = 1'b1;
                    fill_ptr_next = adv(fill_ptr_reg);
                    occ_cnt_next  = occ_cnt_reg + CW'(1);
                end
            end
            scrm_pkg::REQ_PROCESS:
            begin
                slot_ptr = work_ptr_reg;
                if (occ_cnt_reg != proc_cnt_reg)
                begin
                    ctl.status    = scrm_pkg::STAT_DONE;
                    ctl.chg_we    = 1'b1;
                    ctl.len_sel   = 1'b1;
                    work_ptr_next = adv(work_ptr_reg);
                    proc_cnt_next = proc_cnt_reg + CW'(1);
                end
            end
            scrm_pkg::REQ_CONSUME:
            begin
                slot_ptr = drain_ptr_reg;
                if (proc_cnt_reg != '0)
                begin
                    ctl.status  = scrm_pkg::STAT_DONE;
                    ctl.chg_sel = 1'b1;
                end
            end
            scrm_pkg::REQ_RELEASE:
            begin
                slot_ptr = drain_ptr_reg;
                if (proc_cnt_reg != '0)
                begin
                    ctl.status     = scrm_pkg::STAT_DONE;
                    drain_ptr_next = adv(drain_ptr_reg);
                    proc_cnt_next  = proc_cnt_reg - CW'(1);
                    occ_cnt_next   = occ_cnt_reg - CW'(1);
                end
            end
            scrm_pkg::REQ_CLEAR:
            begin
                ctl.status     = scrm_pkg::STAT_DONE;
                fill_ptr_next  = '0;
                work_ptr_next  = '0;
                drain_ptr_next = '0;
                occ_cnt_next   = '0;
                proc_cnt_next  = '0;
            end
            default:
            begin
                ctl.status = scrm_pkg::STAT_BAD_STATE;
            end
        endcase
        if (!req_vld)
        begin
            ctl.len_we     = 1'b0;
            ctl.chg_we     = 1'b0;
            fill_ptr_next  = fill_ptr_reg;
            work_ptr_next  = work_ptr_reg;
            drain_ptr_next = drain_ptr_reg;
            occ_cnt_next   = occ_cnt_reg;
            proc_cnt_next  = proc_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_ptr_reg  <= '0;
            work_ptr_reg  <= '0;
            drain_ptr_reg <= '0;
            occ_cnt_reg   <= '0;
            proc_cnt_reg  <= '0;
        end
        else
        begin
            fill_ptr_reg  <= fill_ptr_next;
            work_ptr_reg  <= work_ptr_next;
            drain_ptr_reg <= drain_ptr_next;
            occ_cnt_reg   <= occ_cnt_next;
            proc_cnt_reg  <= proc_cnt_next;
        end
    end

    assign fill_ptr  = fill_ptr_reg;
    assign work_ptr  = work_ptr_reg;
    assign drain_ptr = drain_ptr_reg;

endmodule

/* sv/three_stage_slot_ring_manager_unit.sv */
// Top level of the three-stage slot ring manager.
//
// The block tracks a ring of NUM_SLOTS frame slots that move from free to
// filled (produce), filled to processed (process), and processed back to
// free (release), with a consume request that peeks at the oldest processed
// slot. A request beat is taken at every rising edge where start is high;
// busy is never raised, so one request can be issued in every cycle. Each
// request yields exactly one result beat, marked by done, after the edge
// that accepted it: the request is registered, decided and applied to the
// pointers in the next cycle, and the result is registered at the end of
// that cycle together with the read of the length and flag RAMs.
// The receiver cannot hold results off, so it must take done beats as they
// come. The one-cycle rate is set by the pointer and occupancy update, which
// completes in a single cycle for every request. The max_frame_len register
// resets to 65535 and should only be written while no request is in flight.
module three_stage_slot_ring_manager_unit #(
    parameter int unsigned NUM_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request channel.
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [15:0] frame_len,
    input  logic        decode_ok,
    // Configuration write port for max_frame_len.
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // Result channel.
    output logic        done,
    output logic [1:0]  status,
    output logic [2:0]  slot_index,
    output logic [15:0] length_out,
    output logic        frame_changed
);

    localparam int unsigned PW = $clog2(NUM_SLOTS);

    // Configuration register.
    logic [15:0] max_len_reg;

    // Request register stage.
    logic        req_vld_reg;
    logic [2:0]  req_type_reg;
    logic [15:0] frame_len_reg;
    logic        decode_ok_reg;

    // Control decisions.
    scrm_pkg::scrm_ctl_t ctl;
    logic [PW-1:0]       slot_ptr;
    logic [PW-1:0]       fill_ptr;
    logic [PW-1:0]       work_ptr;
    logic [PW-1:0]       drain_ptr;
    logic [PW+2:0]       slot_ext;

    // Result register stage.
    logic        done_reg;
    logic [1:0]  status_reg;
    logic [2:0]  idx_reg;
    logic        len_sel_reg;
    logic        chg_sel_reg;

    // RAM read data, registered inside the RAMs and aligned with the result stage.
    logic [15:0] len_rdata;
    logic [0:0]  chg_rdata;

    // The block takes a request in every cycle.
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= 16'hFFFF;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
        end
        else
        begin
            req_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_type_reg  <= req_type;
            frame_len_reg <= frame_len;
            decode_ok_reg <= decode_ok;
        end
    end

    scrm_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_vld       (req_vld_reg),
        .req_type      (req_type_reg),
        .frame_len     (frame_len_reg),
        .max_frame_len (max_len_reg),
        .ctl           (ctl),
        .slot_ptr      (slot_ptr),
        .fill_ptr      (fill_ptr),
        .work_ptr      (work_ptr),
        .drain_ptr     (drain_ptr)
    );

    // Frame lengths are written at the fill pointer and read at the work
    // pointer; a produce always writes a slot before a process can read it.
    scrm_ram #(
        .WIDTH (16),
        .DEPTH (NUM_SLOTS)
    ) u_len_ram (
        .clk   (clk),
        .we    (ctl.len_we),
        .waddr (fill_ptr),
        .wdata (frame_len_reg),
        .raddr (work_ptr),
        .rdata (len_rdata)
    );

    // New-picture flags are written at the work pointer and read at the
    // drain pointer; a consume only reads a slot that a process has written.
    scrm_ram #(
        .WIDTH (1),
        .DEPTH (NUM_SLOTS)
    ) u_chg_ram (
        .clk   (clk),
        .we    (ctl.chg_we),
        .waddr (work_ptr),
        .wdata (decode_ok_reg),
        .raddr (drain_ptr),
        .rdata (chg_rdata)
    );

    // The reported index keeps the low three bits of the slot pointer.
    assign slot_ext = {3'b000, slot_ptr};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= ctl.status;
        idx_reg     <= slot_ext[2:0];
        len_sel_reg <= ctl.len_sel;
        chg_sel_reg <= ctl.chg_sel;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign slot_index    = idx_reg;
    assign length_out    = len_sel_reg ? len_rdata : 16'd0;
    assign frame_changed = chg_sel_reg ? chg_rdata[0] : 1'b0;

endmodule

/* bench/scrm_ring_monitor.sv */
`timescale 1ns / 100ps
// Scoreboard that predicts and checks every result beat of the slot ring manager.
module scrm_ring_monitor #(
    parameter int unsigned SLOTS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [2:0]        req_type,
    input  logic [15:0]       frame_len,
    input  logic              decode_ok,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              done,
    input  logic [1:0]        status,
    input  logic [2:0]        slot_index,
    input  logic [15:0]       length_out,
    input  logic              frame_changed,
    output int unsigned       mismatch_total,
    output int unsigned       results_owed
);

    typedef enum logic [1:0] {
        SLOT_FREE,
        SLOT_FILLED,
        SLOT_PROCESSED
    } slot_phase_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [15:0] length;
        logic        changed;
    } ring_result_t;

    localparam int unsigned REPORT_LIMIT = 10;

    // Shadow copy of the ring. Lengths are only read after a produce wrote them.
    slot_phase_t    phase_of [SLOTS];
    logic           changed_of [SLOTS];
    logic [15:0]    length_of [SLOTS];
    int unsigned    fill_at;
    int unsigned    work_at;
    int unsigned    drain_at;
    logic [15:0]    len_limit;
    ring_result_t   awaited_results [$];
    int unsigned    miss_count;

    function automatic int unsigned next_slot(int unsigned at);
        return (at + 1) % SLOTS;
    endfunction

    // Applies one request to the shadow ring and returns the result it yields.
    function automatic ring_result_t apply_request(logic [2:0] req, logic [15:0] len,
                                                   logic ok);
        ring_result_t r;
        int unsigned  i;
        r = '0;
        r.status = scrm_pkg::STAT_BAD_STATE;
        case (req)
            scrm_pkg::REQ_PRODUCE:
            begin
                r.slot = fill_at[2:0];
                if (len > len_limit)
                begin
                    r.status = scrm_pkg::STAT_TOO_LONG;
                end
                else if (phase_of[fill_at] == SLOT_FREE)
                begin
                    length_of[fill_at] = len;
                    phase_of[fill_at] = SLOT_FILLED;
                    fill_at = next_slot(fill_at);
                    r.status = scrm_pkg::STAT_DONE;
                end
            end
            scrm_pkg::REQ_PROCESS:
            begin
                r.slot = work_at[2:0];
                if (phase_of[work_at] == SLOT_FILLED)
                begin
                    changed_of[work_at] = ok;
                    phase_of[work_at] = SLOT_PROCESSED;
                    r.length = length_of[work_at];
                    work_at = next_slot(work_at);
                    r.status = scrm_pkg::STAT_DONE;
                end
            end
            scrm_pkg::REQ_CONSUME:
            begin
                r.slot = drain_at[2:0];
                if (phase_of[drain_at] == SLOT_PROCESSED)
                begin
                    r.changed = changed_of[drain_at];
                    r.status = scrm_pkg::STAT_DONE;
                end
            end
            scrm_pkg::REQ_RELEASE:
            begin
                r.slot = drain_at[2:0];
                if (phase_of[drain_at] == SLOT_PROCESSED)
                begin
                    phase_of[drain_at] = SLOT_FREE;
                    drain_at = next_slot(drain_at);
                    r.status = scrm_pkg::STAT_DONE;
                end
            end
            scrm_pkg::REQ_CLEAR:
            begin
                // Lengths and flags survive a clear; only occupancy and pointers reset.
                for (i = 0; i < SLOTS; i++)
                begin
                    phase_of[i] = SLOT_FREE;
                end
                fill_at = 0;
                work_at = 0;
                drain_at = 0;
                r.status = scrm_pkg::STAT_DONE;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        ring_result_t seen;
        ring_result_t want;
        ring_result_t fresh;
        int unsigned  i;
        if (!rst_n)
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                phase_of[i] = SLOT_FREE;
                changed_of[i] = 1'b0;
            end
            fill_at = 0;
            work_at = 0;
            drain_at = 0;
            len_limit = 16'hFFFF;
            awaited_results.delete();
            miss_count = 0;
        end
        else
        begin
            // Results leave through the request and result registers, so the oldest
            // expectation is matched before this edge's request is added.
            if (done === 1'b1)
            begin
                seen = {status, slot_index, length_out, frame_changed};
                if (awaited_results.size() == 0)
                begin
                    miss_count++;
                    if (miss_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: result beat with none expected:",
                                 $realtime,
                                 " status %0d slot %0d len %0d chg %0d",
                                 seen.status, seen.slot, seen.length, seen.changed);
                    end
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (seen.status !== want.status || seen.slot !== want.slot ||
                        seen.length !== want.length || seen.changed !== want.changed)
                    begin
                        miss_count++;
                        if (miss_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: result mismatch: expected status %0d",
                                     $realtime, want.status,
                                     " slot %0d len %0d chg %0d,",
                                     want.slot, want.length, want.changed,
                                     " got status %0d slot %0d len %0d chg %0d",
                                     seen.status, seen.slot, seen.length,
                                     seen.changed);
                        end
                    end
                end
            end
            if (cfg_wr_en === 1'b1)
            begin
                len_limit = cfg_wr_data;
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                fresh = apply_request(req_type, frame_len, decode_ok);
                awaited_results.insert(awaited_results.size(), fresh);
            end
        end
        mismatch_total <= miss_count;
        results_owed <= awaited_results.size();
    end

endmodule

/* bench/tb_three_stage_slot_ring_manager_unit.sv */
`timescale 1ns / 100ps
// Testbench top for the three-stage slot ring manager: stimulus, reset and verdict.
module tb_three_stage_slot_ring_manager_unit;

    localparam int unsigned SLOTS = 8;

    // Request codes the block does not define; each must come back as a bad-state result.
    localparam logic [2:0] REQ_UNUSED_A = 3'd5;
    localparam logic [2:0] REQ_UNUSED_B = 3'd6;
    localparam logic [2:0] REQ_UNUSED_C = 3'd7;

    localparam int unsigned TRAFFIC_PHASES = 6;
    localparam int unsigned BEATS_PER_PHASE = 250;
    // The phase that runs with the request side never pausing.
    localparam int unsigned STEADY_PHASE = 2;
    // Extra wait after the last owed result, to cover any slack.
    localparam int unsigned SETTLE_CYCLES = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  req_type = scrm_pkg::REQ_CLEAR;
    logic [15:0] frame_len = '0;
    logic        decode_ok = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        done;
    logic [1:0]  status;
    logic [2:0]  slot_index;
    logic [15:0] length_out;
    logic        frame_changed;

    int unsigned mismatch_total;
    int unsigned results_owed;

    // Value of max_frame_len the block currently holds, used to aim lengths
    // at the accept/reject boundary.
    logic [15:0] len_limit_now = 16'hFFFF;
    logic [15:0] limit_plan [TRAFFIC_PHASES];

    three_stage_slot_ring_manager_unit #(
        .NUM_SLOTS (SLOTS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .frame_len     (frame_len),
        .decode_ok     (decode_ok),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .done          (done),
        .status        (status),
        .slot_index    (slot_index),
        .length_out    (length_out),
        .frame_changed (frame_changed)
    );

    // The monitor sees the same pins as the block and does all the checking.
    scrm_ring_monitor #(
        .SLOTS (SLOTS)
    ) u_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .frame_len      (frame_len),
        .decode_ok      (decode_ok),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .done           (done),
        .status         (status),
        .slot_index     (slot_index),
        .length_out     (length_out),
        .frame_changed  (frame_changed),
        .mismatch_total (mismatch_total),
        .results_owed   (results_owed)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Presents one request beat and returns at the edge that takes it. Start is
    // left high so that back-to-back beats never drop it for a cycle; only a
    // pause or a drain wait lowers it.
    task automatic offer_request(input logic [2:0] req, input logic [15:0] len,
                                 input logic ok);
        start <= 1'b1;
        req_type <= req;
        frame_len <= len;
        decode_ok <= ok;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    // One cycle with no request. The fields carry junk to show they are ignored.
    task automatic pause_one_cycle();
        start <= 1'b0;
        req_type <= 3'($urandom);
        frame_len <= 16'($urandom);
        decode_ok <= 1'($urandom);
        @(posedge clk);
    endtask

    // Waits until every result beat owed by the block has arrived, then a few
    // cycles more so that nothing is still in flight inside it.
    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes max_frame_len. Only called while the block is drained.
    task automatic set_len_limit(input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        len_limit_now = value;
    endtask

    // Frame lengths: mostly legal, with many hits on the limit and just past
    // it, and some drawn from the whole 16-bit range.
    function automatic logic [15:0] offered_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            return 16'($urandom_range(0, len_limit_now));
        end
        else if (roll < 65)
        begin
            return len_limit_now;
        end
        else if (roll < 80)
        begin
            return (len_limit_now == '1) ? len_limit_now : len_limit_now + 16'd1;
        end
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // Random traffic. Requests come in bursts of one kind so that the ring
    // swings between full and empty and the three pointers chase each other
    // around the wrap; a small share of clears, undefined codes and arbitrary
    // kinds is mixed in as noise.
    task automatic run_traffic_phase(input int unsigned beats, input bit may_pause);
        int unsigned sent;
        int unsigned burst_left;
        int unsigned roll;
        logic [2:0]  burst_kind;
        logic [2:0]  req;
        sent = 0;
        burst_left = 0;
        burst_kind = scrm_pkg::REQ_PRODUCE;
        while (sent < beats)
        begin
            if (may_pause)
            begin
                while ($urandom_range(0, 99) < 22)
                begin
                    pause_one_cycle();
                end
            end
            if (burst_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: burst_kind = scrm_pkg::REQ_PRODUCE;
                    1: burst_kind = scrm_pkg::REQ_PROCESS;
                    2: burst_kind = scrm_pkg::REQ_CONSUME;
                    default: burst_kind = scrm_pkg::REQ_RELEASE;
                endcase
                burst_left = $urandom_range(1, 9);
            end
            burst_left--;
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                req = scrm_pkg::REQ_CLEAR;
            end
            else if (roll < 5)
            begin
                req = 3'($urandom_range(REQ_UNUSED_A, REQ_UNUSED_C));
            end
            else if (roll < 10)
            begin
                req = 3'($urandom_range(scrm_pkg::REQ_PRODUCE, scrm_pkg::REQ_RELEASE));
            end
            else
            begin
                req = burst_kind;
            end
            offer_request(req, offered_len(), 1'($urandom_range(0, 1)));
            sent++;
        end
    endtask

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned i;

        // Reset is held low from the start and never asserted again.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats with max_frame_len still at its reset value of all ones.
        // The longest frame is legal here, and its length must come back on process.
        offer_request(scrm_pkg::REQ_PRODUCE, 16'hFFFF, 1'b0);
        offer_request(scrm_pkg::REQ_PRODUCE, 16'h0000, 1'b1);
        offer_request(scrm_pkg::REQ_PROCESS, 16'h1234, 1'b1);
        // Peeking at a processed slot gives its new-picture flag without moving.
        offer_request(scrm_pkg::REQ_CONSUME, 16'h0000, 1'b0);
        offer_request(scrm_pkg::REQ_PROCESS, 16'hFFFF, 1'b0);
        // The work pointer now sits on a free slot.
        offer_request(scrm_pkg::REQ_PROCESS, 16'h0000, 1'b1);
        offer_request(scrm_pkg::REQ_RELEASE, 16'h0000, 1'b0);
        offer_request(scrm_pkg::REQ_CONSUME, 16'hFFFF, 1'b1);
        offer_request(scrm_pkg::REQ_RELEASE, 16'h0000, 1'b0);
        // Release and consume on a slot that is not processed are refused.
        offer_request(scrm_pkg::REQ_RELEASE, 16'h0000, 1'b1);
        offer_request(scrm_pkg::REQ_CONSUME, 16'h0000, 1'b1);
        // Undefined request codes change nothing.
        offer_request(REQ_UNUSED_A, 16'hFFFF, 1'b1);
        offer_request(REQ_UNUSED_B, 16'hFFFF, 1'b1);
        offer_request(REQ_UNUSED_C, 16'hFFFF, 1'b1);
        // A clear drops a filled slot, so the next process finds nothing.
        offer_request(scrm_pkg::REQ_PRODUCE, 16'hA5A5, 1'b0);
        offer_request(scrm_pkg::REQ_CLEAR, 16'h5A5A, 1'b1);
        offer_request(scrm_pkg::REQ_PROCESS, 16'h0000, 1'b1);

        // With the limit at zero only empty frames fit.
        wait_for_drain();
        set_len_limit(16'h0000);
        offer_request(scrm_pkg::REQ_PRODUCE, 16'h0001, 1'b0);
        offer_request(scrm_pkg::REQ_PRODUCE, 16'hFFFF, 1'b0);
        for (i = 0; i < SLOTS; i++)
        begin
            offer_request(scrm_pkg::REQ_PRODUCE, 16'h0000, 1'b0);
        end
        // The ring is full: a legal length meets a slot in the wrong state, while
        // an over-long one is rejected for its length first.
        offer_request(scrm_pkg::REQ_PRODUCE, 16'h0000, 1'b0);
        offer_request(scrm_pkg::REQ_PRODUCE, 16'h0001, 1'b0);
        offer_request(scrm_pkg::REQ_CLEAR, 16'h0000, 1'b0);

        // Random traffic under several limits, both extremes among them.
        limit_plan[0] = 16'hFFFF;
        limit_plan[1] = 16'h0000;
        limit_plan[2] = 16'($urandom_range(2, 16'hFFFD));
        limit_plan[3] = 16'h0001;
        limit_plan[4] = 16'($urandom_range(2, 16'hFFFD));
        limit_plan[5] = 16'hFFFE;
        for (phase = 0; phase < TRAFFIC_PHASES; phase++)
        begin
            wait_for_drain();
            set_len_limit(limit_plan[phase]);
            run_traffic_phase(BEATS_PER_PHASE, phase != STEADY_PHASE);
        end

        wait_for_drain();
        if (mismatch_total == 0 && results_owed == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // About 1500 random beats plus directed beats and pauses; this bound is
    // far beyond any correct run.
    initial
    begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
sv/scrm_pkg.sv
sv/scrm_ram.sv
sv/scrm_ctrl.sv
sv/three_stage_slot_ring_manager_unit.sv
bench/scrm_ring_monitor.sv
bench/tb_three_stage_slot_ring_manager_unit.sv
